// ===== rtl/core/hrd_pkg.sv =====
// Package for the HTTP response deframer: phase codes, result type and
// character helpers. No dependencies.
`default_nettype none
package hrd_pkg;

  localparam int unsigned LINE_LIMIT_DEF = 1024;

  typedef enum logic [5:0] {
    PH_STATUS  = 6'b000001,
    PH_HEADERS = 6'b000010,
    PH_BLOCK   = 6'b000100,
    PH_CSIZE   = 6'b001000,
    PH_CDATA   = 6'b010000,
    PH_TRAILER = 6'b100000
  } phase_t;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_DONE = 2'd1;
  localparam logic [1:0] EV_FAIL = 2'd2;

  typedef struct packed {
    logic        body_valid;
    logic [7:0]  body_byte;
    logic [1:0]  event_res;
    logic [15:0] status_code;
    logic        close_connection;
  } result_t;

  function automatic logic [7:0] lower_ch(input logic [7:0] c);
    lower_ch = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30 && c <= 8'h39);
  endfunction

  // hex value with bit 4 set when c is not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] l;
    l = lower_ch(c);
    if (is_digit(c)) hex_val = {1'b0, c[3:0]};
    else if (l >= 8'h61 && l <= 8'h66) hex_val = {1'b0, l[3:0] + 4'd9};
    else hex_val = 5'h10;
  endfunction

  function automatic logic [7:0] te_char(input logic [4:0] p);
    case (p)
      5'd0: te_char = "t";  5'd1: te_char = "r";  5'd2: te_char = "a";
      5'd3: te_char = "n";  5'd4: te_char = "s";  5'd5: te_char = "f";
      5'd6: te_char = "e";  5'd7: te_char = "r";  5'd8: te_char = "-";
      5'd9: te_char = "e";  5'd10: te_char = "n"; 5'd11: te_char = "c";
      5'd12: te_char = "o"; 5'd13: te_char = "d"; 5'd14: te_char = "i";
      5'd15: te_char = "n"; 5'd16: te_char = "g";
      default: te_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] cl_char(input logic [4:0] p);
    case (p)
      5'd0: cl_char = "c";  5'd1: cl_char = "o";  5'd2: cl_char = "n";
      5'd3: cl_char = "t";  5'd4: cl_char = "e";  5'd5: cl_char = "n";
      5'd6: cl_char = "t";  5'd7: cl_char = "-";  5'd8: cl_char = "l";
      5'd9: cl_char = "e";  5'd10: cl_char = "n"; 5'd11: cl_char = "g";
      5'd12: cl_char = "t"; 5'd13: cl_char = "h";
      default: cl_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ck_char(input logic [3:0] p);
    case (p)
      4'd0: ck_char = "c"; 4'd1: ck_char = "h"; 4'd2: ck_char = "u";
      4'd3: ck_char = "n"; 4'd4: ck_char = "k"; 4'd5: ck_char = "e";
      4'd6: ck_char = "d";
      default: ck_char = 8'h00;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/http_response_deframer_unit.sv =====
// Top level of the HTTP response deframer: stream ports, APB registers and
// the output register. Depends on hrd_pkg and hrd_parser.
`default_nettype none
// One request (a received byte or a new-request marker) is taken per clock while
// in_tready is high and yields exactly one result, registered into the output
// register, or into the skid entry when the output is stalled. A one-entry
// output register with a skid entry keeps input accepted while a result waits.
// Register 0 (addr 0x0) is keep_alive, register 1 (addr 0x4) is head_request;
// write them only while the block is idle.
module http_response_deframer_unit #(
  parameter int unsigned LINE_LIMIT = hrd_pkg::LINE_LIMIT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [0] body_valid, [8:1] body_byte,
                                       // [10:9] event_res, [26:11] status_code,
                                       // [27] close_connection, rest zero
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam logic [2:0] ADDR_KEEP = 3'd0;
  localparam logic [2:0] ADDR_HEAD = 3'd4;

  logic keep_r, head_r;
  logic step;
  hrd_pkg::result_t res;
  hrd_pkg::result_t out_r, skid_r;
  logic out_v_r, skid_v_r;

  assign cfg_pready = 1'b1;

  // register write and read back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= 1'b1; head_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr == ADDR_KEEP) keep_r <= cfg_pwdata[0];
      if (cfg_paddr == ADDR_HEAD) head_r <= cfg_pwdata[0];
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      ADDR_KEEP: cfg_prdata = {31'd0, keep_r};
      ADDR_HEAD: cfg_prdata = {31'd0, head_r};
      default:   cfg_prdata = 32'd0;
    endcase
  end

  // accept while the skid entry is free
  assign in_tready = !skid_v_r;
  assign step = in_tvalid && in_tready;

  hrd_parser #(.LINE_LIMIT(LINE_LIMIT)) u_parser (
    .clk(clk), .rst_n(rst_n), .step(step), .action(in_tuser),
    .data_byte(in_tdata), .keep_alive(keep_r), .head_request(head_r), .res(res)
  );

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0; skid_v_r <= 1'b0;
    end else begin
      if (!out_v_r || out_tready) begin
        if (skid_v_r) begin
          out_r <= skid_r; out_v_r <= 1'b1; skid_v_r <= 1'b0;
          if (step) begin
            skid_r <= res; skid_v_r <= 1'b1;
          end
        end else begin
          out_v_r <= step;
          if (step) out_r <= res;
        end
      end else if (step) begin
        skid_r <= res; skid_v_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = {4'd0, out_r.close_connection, out_r.status_code,
                      out_r.event_res, out_r.body_byte, out_r.body_valid};

  a_skid_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid holds data while output empty");
  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> !in_tready) else $error("request taken with skid full");
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready) |=> (out_v_r && $stable(out_tdata)))
    else $error("stalled result changed");
endmodule
`default_nettype wire

// ===== rtl/core/hrd_parser.sv =====
// Per-byte parse engine of the HTTP response deframer.
// Depends on hrd_pkg. Holds all parse state; one byte per enabled cycle.
`default_nettype none
module hrd_parser #(
  parameter int unsigned LINE_LIMIT = hrd_pkg::LINE_LIMIT_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire logic            action,
  input  wire logic [7:0]      data_byte,
  input  wire logic            keep_alive,
  input  wire logic            head_request,
  output hrd_pkg::result_t     res
);
  localparam int LW = $clog2(LINE_LIMIT + 1);

  hrd_pkg::phase_t ph_r, ph_nxt;
  logic [1:0]  sub_r, sub_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [15:0] code_r, code_nxt;
  logic [31:0] rem_r, rem_nxt, clv_r, clv_nxt;
  logic        lseen_r, lseen_nxt, cseen_r, cseen_nxt;
  logic [4:0]  npos_r, npos_nxt;
  logic [1:0]  nflg_r, nflg_nxt;
  logic [3:0]  vpos_r, vpos_nxt;
  logic        fail_r, fail_nxt;

  logic [7:0]  c, lc;
  logic [1:0]  ev;
  logic        bv;
  logic        dlm, term, cnt_ok;
  logic [4:0]  hv;
  logic [1:0]  m;
  logic [19:0] code_t;
  logic [35:0] clv_t;
  logic [LW-1:0] len_inc;

  always_comb begin
    c = data_byte;
    lc = hrd_pkg::lower_ch(c);
    hv = hrd_pkg::hex_val(c);
    dlm = (c == ":" || c == " " || c == 8'h09);
    term = (c == ";" || c == " " || c == 8'h0D || c == 8'h09);
    code_t = ({4'd0, code_r} << 3) + ({4'd0, code_r} << 1) + 20'(c - 8'h30);
    clv_t = ({4'd0, clv_r} << 3) + ({4'd0, clv_r} << 1) + 36'(c - 8'h30);
    len_inc = len_r + 1'b1;
    cnt_ok = (32'(len_inc) < LINE_LIMIT);
    m = 2'b00;

    ph_nxt = ph_r; sub_nxt = sub_r; len_nxt = len_r; code_nxt = code_r;
    rem_nxt = rem_r; clv_nxt = clv_r; lseen_nxt = lseen_r; cseen_nxt = cseen_r;
    npos_nxt = npos_r; nflg_nxt = nflg_r; vpos_nxt = vpos_r; fail_nxt = fail_r;
    ev = hrd_pkg::EV_NONE; bv = 1'b0;

    if (action) begin
      ph_nxt = hrd_pkg::PH_STATUS; sub_nxt = '0; len_nxt = '0; npos_nxt = '0;
      nflg_nxt = 2'b11; vpos_nxt = '0; code_nxt = '0; rem_nxt = '0; clv_nxt = '0;
      lseen_nxt = 1'b0; cseen_nxt = 1'b0; fail_nxt = 1'b0;
    end else if (!fail_r) begin
      unique case (ph_r)
        hrd_pkg::PH_STATUS: begin
          if (c == 8'h0A) begin
            sub_nxt = '0; len_nxt = '0; npos_nxt = '0; nflg_nxt = 2'b11; vpos_nxt = '0;
            if (sub_r == 2'd1) begin
              fail_nxt = 1'b1; ev = hrd_pkg::EV_FAIL;
            end else if (sub_r >= 2'd2) ph_nxt = hrd_pkg::PH_HEADERS;
          end else if (sub_r == 2'd0) begin
            if (c == " " || c == 8'h09) begin
              sub_nxt = 2'd1; code_nxt = '0;
            end
          end else if (sub_r == 2'd1) begin
            if (!(c == " " || c == 8'h09)) begin
              if (hrd_pkg::is_digit(c)) begin
                code_nxt = {12'd0, c[3:0]}; sub_nxt = 2'd2;
              end else sub_nxt = 2'd3;
            end
          end else if (sub_r == 2'd2) begin
            if (hrd_pkg::is_digit(c))
              code_nxt = (code_t > 20'hFFFF) ? 16'hFFFF : code_t[15:0];
            else sub_nxt = 2'd3;
          end
        end
        hrd_pkg::PH_HEADERS: begin
          if (c == 8'h0A) begin
            sub_nxt = '0; len_nxt = '0; npos_nxt = '0; nflg_nxt = 2'b11; vpos_nxt = '0;
            if (len_r == '0 || (len_r == LW'(1) && sub_r == 2'd3 && npos_r == 5'd1)) begin
              if (code_r == 16'd100) ph_nxt = hrd_pkg::PH_STATUS;
              else if (code_r == 16'd200 && !head_request) begin
                if (cseen_r) begin
                  ph_nxt = hrd_pkg::PH_CSIZE; rem_nxt = '0;
                end else if (!lseen_r) begin
                  fail_nxt = 1'b1; ev = hrd_pkg::EV_FAIL;
                end else if (clv_r == '0) begin
                  ph_nxt = hrd_pkg::PH_STATUS; ev = hrd_pkg::EV_DONE;
                end else begin
                  rem_nxt = clv_r; ph_nxt = hrd_pkg::PH_BLOCK;
                end
              end else begin
                ph_nxt = hrd_pkg::PH_STATUS; ev = hrd_pkg::EV_DONE;
              end
            end else if (sub_r >= 2'd1 && nflg_r[0]) begin
              cseen_nxt = (vpos_r == 4'd7);
            end
          end else if (!cnt_ok) begin
            fail_nxt = 1'b1; ev = hrd_pkg::EV_FAIL; sub_nxt = '0; len_nxt = '0;
            npos_nxt = '0; nflg_nxt = 2'b11; vpos_nxt = '0;
          end else begin
            len_nxt = len_inc;
            if (sub_r == 2'd0) begin
              if (dlm) begin
                m[0] = nflg_r[0] && npos_r == 5'd17;
                m[1] = nflg_r[1] && npos_r == 5'd14;
                nflg_nxt = m; vpos_nxt = '0;
                sub_nxt = (m != 2'b00) ? 2'd1 : 2'd3;
                if (m[1]) begin
                  clv_nxt = '0; lseen_nxt = 1'b1;
                end
              end else if (c == 8'h0D) begin
                nflg_nxt = 2'b00; sub_nxt = 2'd3;
                if (npos_r < 5'd31) npos_nxt = npos_r + 5'd1;
              end else begin
                if (!(npos_r < 5'd17 && hrd_pkg::te_char(npos_r) == lc)) nflg_nxt[0] = 1'b0;
                if (!(npos_r < 5'd14 && hrd_pkg::cl_char(npos_r) == lc)) nflg_nxt[1] = 1'b0;
                if (npos_r < 5'd31) npos_nxt = npos_r + 5'd1;
              end
            end else if (sub_r == 2'd1 && dlm) begin
              sub_nxt = 2'd1;
            end else if (sub_r == 2'd1 || sub_r == 2'd2) begin
              sub_nxt = 2'd2;
              if (nflg_r[0]) begin
                if (c == 8'h0D) sub_nxt = 2'd3;
                else if (vpos_r < 4'd7 && lc == hrd_pkg::ck_char(vpos_r))
                  vpos_nxt = vpos_r + 4'd1;
                else vpos_nxt = 4'd15;
              end else begin
                if (hrd_pkg::is_digit(c))
                  clv_nxt = (clv_t > 36'hFFFFFFFF) ? 32'hFFFFFFFF : clv_t[31:0];
                else sub_nxt = 2'd3;
              end
            end
          end
        end
        hrd_pkg::PH_BLOCK, hrd_pkg::PH_CDATA: begin
          bv = 1'b1;
          if (rem_r <= 32'd1) begin
            rem_nxt = '0; sub_nxt = '0; len_nxt = '0; npos_nxt = '0;
            nflg_nxt = 2'b11; vpos_nxt = '0;
            if (ph_r == hrd_pkg::PH_BLOCK) begin
              ph_nxt = hrd_pkg::PH_STATUS; ev = hrd_pkg::EV_DONE;
            end else ph_nxt = hrd_pkg::PH_CSIZE;
          end else rem_nxt = rem_r - 32'd1;
        end
        hrd_pkg::PH_CSIZE: begin
          if (c == 8'h0A) begin
            if (sub_r == 2'd1 || sub_r == 2'd2)
              ph_nxt = (rem_r != '0) ? hrd_pkg::PH_CDATA : hrd_pkg::PH_TRAILER;
            sub_nxt = '0; len_nxt = '0; npos_nxt = '0; nflg_nxt = 2'b11; vpos_nxt = '0;
          end else if (!cnt_ok) begin
            fail_nxt = 1'b1; ev = hrd_pkg::EV_FAIL; sub_nxt = '0; len_nxt = '0;
            npos_nxt = '0; nflg_nxt = 2'b11; vpos_nxt = '0;
          end else begin
            len_nxt = len_inc;
            if (sub_r == 2'd0) begin
              if (term) sub_nxt = 2'd3;
              else if (!hv[4]) begin
                rem_nxt = {28'd0, hv[3:0]}; sub_nxt = 2'd1;
              end else begin
                rem_nxt = '0; sub_nxt = 2'd2;
              end
            end else if (sub_r == 2'd1) begin
              if (!hv[4] && !term) begin
                if (rem_r > 32'h0FFFFFFF) rem_nxt = 32'hFFFFFFFF;
                else rem_nxt = {rem_r[27:0], hv[3:0]};
              end else sub_nxt = 2'd2;
            end
          end
        end
        hrd_pkg::PH_TRAILER: begin
          if (c == 8'h0A) begin
            sub_nxt = '0; len_nxt = '0; npos_nxt = '0; nflg_nxt = 2'b11; vpos_nxt = '0;
            if (len_r == '0 || (len_r == LW'(1) && sub_r == 2'd1)) begin
              ph_nxt = hrd_pkg::PH_STATUS; ev = hrd_pkg::EV_DONE;
            end
          end else if (!cnt_ok) begin
            fail_nxt = 1'b1; ev = hrd_pkg::EV_FAIL; sub_nxt = '0; len_nxt = '0;
            npos_nxt = '0; nflg_nxt = 2'b11; vpos_nxt = '0;
          end else begin
            len_nxt = len_inc;
            if (len_inc == LW'(1)) sub_nxt = (c == 8'h0D) ? 2'd1 : 2'd2;
            else sub_nxt = 2'd2;
          end
        end
        default: begin
          ph_nxt = hrd_pkg::PH_STATUS;
        end
      endcase
    end

    res.body_valid = bv;
    res.body_byte = bv ? c : 8'd0;
    res.event_res = ev;
    res.status_code = code_nxt;
    res.close_connection = (ev == hrd_pkg::EV_DONE) && !keep_alive;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= hrd_pkg::PH_STATUS; sub_r <= '0; len_r <= '0; code_r <= '0;
      rem_r <= '0; clv_r <= '0; lseen_r <= 1'b0; cseen_r <= 1'b0;
      npos_r <= '0; nflg_r <= 2'b11; vpos_r <= '0; fail_r <= 1'b0;
    end else if (step) begin
      ph_r <= ph_nxt; sub_r <= sub_nxt; len_r <= len_nxt; code_r <= code_nxt;
      rem_r <= rem_nxt; clv_r <= clv_nxt; lseen_r <= lseen_nxt; cseen_r <= cseen_nxt;
      npos_r <= npos_nxt; nflg_r <= nflg_nxt; vpos_r <= vpos_nxt; fail_r <= fail_nxt;
    end
  end

  // body bytes only come out of a body phase
  a_body_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.body_valid) |-> (ph_r == hrd_pkg::PH_BLOCK || ph_r == hrd_pkg::PH_CDATA))
    else $error("body byte outside body phase");
  // a failed parser stays silent until a new request
  a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (step && fail_r && !action) |=> fail_r)
    else $error("failed flag dropped without new request");
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    res.close_connection |-> (res.event_res == hrd_pkg::EV_DONE))
    else $error("close without completion");
endmodule
`default_nettype wire
